FILE: rtl/rtoh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtoh_pkg;

    // Channel width that is taken from each input port, and hue fraction bits
    localparam int CHANNEL_BITS  = 8;
    localparam int HUE_FRAC_BITS = 6;

    // Fixed port field widths
    localparam int IN_W   = 8;
    localparam int HUE_W  = 15;
    localparam int SAT_W  = 17;
    localparam int VAL_W  = 8;
    localparam int SAT_FRAC = 16;

    // Hue scale: 60 and 360 degrees in fractional units
    localparam int HUE_DEG60 = 60 << HUE_FRAC_BITS;
    localparam int HUE_FULL  = 360 << HUE_FRAC_BITS;

    // Hue quotient bits, and the wider of hue and saturation; one cell per bit
    localparam int HUE_Q_BITS = $clog2(6 * HUE_DEG60);
    localparam int DIV_BITS   = (SAT_W > HUE_Q_BITS) ? SAT_W : HUE_Q_BITS;

    // Channel width and the widths of the hue numerator as it is formed
    localparam int CW      = CHANNEL_BITS;
    localparam int BASE_W  = CW + 3;
    localparam int K_W     = $clog2(HUE_DEG60 + 1);
    localparam int HPROD_W = BASE_W + K_W;
    localparam int NUM_W   = CW + DIV_BITS;

    // One beat as it travels down the divider chain
    typedef struct packed {
        logic                black;
        logic                grey;
        logic                neg;
        logic [CW-1:0]       sat_den;
        logic [CW-1:0]       sat_rem;
        logic [DIV_BITS-1:0] sat_lo;
        logic [CW-1:0]       hue_den;
        logic [CW-1:0]       hue_rem;
        logic [DIV_BITS-1:0] hue_lo;
    } t_beat;

endpackage

`default_nettype wire

FILE: rtl/rtoh_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rtoh_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [rtoh_pkg::IN_W-1:0] i_red,
    input  wire logic [rtoh_pkg::IN_W-1:0] i_green,
    input  wire logic [rtoh_pkg::IN_W-1:0] i_blue,
    output logic                        o_ready,
    output logic                        o_valid,
    output rtoh_pkg::t_beat             o_beat,
    input  wire logic                   i_ready
);

    logic [rtoh_pkg::CW-1:0]      red_ch;
    logic [rtoh_pkg::CW-1:0]      green_ch;
    logic [rtoh_pkg::CW-1:0]      blue_ch;
    logic [rtoh_pkg::CW-1:0]      mx;
    logic [rtoh_pkg::CW-1:0]      mn;
    logic [rtoh_pkg::CW-1:0]      delta;
    logic [rtoh_pkg::BASE_W-1:0]  hbase;
    logic [rtoh_pkg::HPROD_W-1:0] hprod;
    logic [rtoh_pkg::NUM_W-1:0]   hue_num;
    logic [rtoh_pkg::NUM_W-1:0]   sat_num;
    logic                         neg;
    rtoh_pkg::t_beat              n_beat;
    rtoh_pkg::t_beat              r_beat;
    logic                         r_valid;

    assign red_ch   = rtoh_pkg::CW'(i_red);
    assign green_ch = rtoh_pkg::CW'(i_green);
    assign blue_ch  = rtoh_pkg::CW'(i_blue);

    // Find largest and smallest channel
    always_comb begin
        mx = red_ch;
        if (green_ch > mx) begin
            mx = green_ch;
        end
        if (blue_ch > mx) begin
            mx = blue_ch;
        end
        mn = red_ch;
        if (green_ch < mn) begin
            mn = green_ch;
        end
        if (blue_ch < mn) begin
            mn = blue_ch;
        end
    end

    assign delta = mx - mn;

    // Pick sector base and channel difference; red wins ties, then green
    always_comb begin
        neg = 1'b0;
        if (red_ch == mx) begin
            if (green_ch >= blue_ch) begin
                hbase = rtoh_pkg::BASE_W'(green_ch) - rtoh_pkg::BASE_W'(blue_ch);
            end else begin
                hbase = rtoh_pkg::BASE_W'(blue_ch) - rtoh_pkg::BASE_W'(green_ch);
                neg   = 1'b1;
            end
        end else if (green_ch == mx) begin
            hbase = (rtoh_pkg::BASE_W'(delta) << 1) + rtoh_pkg::BASE_W'(blue_ch)
                    - rtoh_pkg::BASE_W'(red_ch);
        end else begin
            hbase = (rtoh_pkg::BASE_W'(delta) << 2) + rtoh_pkg::BASE_W'(red_ch)
                    - rtoh_pkg::BASE_W'(green_ch);
        end
    end

    // Scale by 60 degrees; the numerator is below delta times 2^DIV_BITS
    assign hprod   = rtoh_pkg::HPROD_W'(hbase) * rtoh_pkg::HPROD_W'(rtoh_pkg::HUE_DEG60);
    assign hue_num = rtoh_pkg::NUM_W'(hprod);
    assign sat_num = rtoh_pkg::NUM_W'(delta) << rtoh_pkg::SAT_FRAC;

    always_comb begin
        n_beat.black   = (mx == '0);
        n_beat.grey    = (delta == '0);
        n_beat.neg     = neg;
        n_beat.sat_den = mx;
        n_beat.sat_rem = sat_num[rtoh_pkg::NUM_W-1 -: rtoh_pkg::CW];
        n_beat.sat_lo  = sat_num[rtoh_pkg::DIV_BITS-1:0];
        n_beat.hue_den = delta;
        n_beat.hue_rem = hue_num[rtoh_pkg::NUM_W-1 -: rtoh_pkg::CW];
        n_beat.hue_lo  = hue_num[rtoh_pkg::DIV_BITS-1:0];
    end

    assign o_ready = !r_valid || i_ready;

    // Register the beat when the stage is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

FILE: rtl/rtoh_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module rtoh_div_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire rtoh_pkg::t_beat i_beat,
    output logic                 o_ready,
    output logic                 o_valid,
    output rtoh_pkg::t_beat      o_beat,
    input  wire logic            i_ready
);

    // One restoring step: shift in the next numerator bit, subtract if it fits
    function automatic logic [rtoh_pkg::CW+rtoh_pkg::DIV_BITS-1:0] div_step(
        input logic [rtoh_pkg::CW-1:0]       rem,
        input logic [rtoh_pkg::DIV_BITS-1:0] lo,
        input logic [rtoh_pkg::CW-1:0]       den
    );
        logic [rtoh_pkg::CW:0]   trial;
        logic [rtoh_pkg::CW:0]   diff;
        logic [rtoh_pkg::CW-1:0] nrem;
        logic                    qbit;
        trial = {rem, lo[rtoh_pkg::DIV_BITS-1]};
        diff  = trial - {1'b0, den};
        qbit  = (trial >= {1'b0, den});
        nrem  = qbit ? diff[rtoh_pkg::CW-1:0] : trial[rtoh_pkg::CW-1:0];
        return {nrem, lo[rtoh_pkg::DIV_BITS-2:0], qbit};
    endfunction

    rtoh_pkg::t_beat n_beat;
    rtoh_pkg::t_beat r_beat;
    logic            r_valid;

    // Advance both dividers by one quotient bit
    always_comb begin
        n_beat = i_beat;
        {n_beat.sat_rem, n_beat.sat_lo} = div_step(i_beat.sat_rem, i_beat.sat_lo,
                                                   i_beat.sat_den);
        {n_beat.hue_rem, n_beat.hue_lo} = div_step(i_beat.hue_rem, i_beat.hue_lo,
                                                   i_beat.hue_den);
    end

    assign o_ready = !r_valid || i_ready;

    // Hold or advance the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

FILE: rtl/rtoh_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rtoh_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire rtoh_pkg::t_beat             i_beat,
    output logic                             o_ready,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [rtoh_pkg::HUE_W-1:0]       o_hue,
    output logic [rtoh_pkg::SAT_W-1:0]       o_saturation,
    output logic [rtoh_pkg::VAL_W-1:0]       o_value,
    output logic                             o_hue_valid
);

    logic [31:0]                 wrapped;
    logic [rtoh_pkg::HUE_W-1:0]  n_hue;
    logic [rtoh_pkg::SAT_W-1:0]  n_sat;
    logic [rtoh_pkg::HUE_W-1:0]  r_hue;
    logic [rtoh_pkg::SAT_W-1:0]  r_sat;
    logic [rtoh_pkg::VAL_W-1:0]  r_val;
    logic                        r_hue_valid;
    logic                        r_valid;

    // Wrap a negative hue into the top of the circle
    assign wrapped = 32'(rtoh_pkg::HUE_FULL) - 32'(i_beat.hue_lo);

    always_comb begin
        if (i_beat.black || i_beat.grey) begin
            n_hue = '0;
        end else if (i_beat.neg) begin
            n_hue = (i_beat.hue_lo == '0) ? '0 : rtoh_pkg::HUE_W'(wrapped);
        end else begin
            n_hue = rtoh_pkg::HUE_W'(i_beat.hue_lo);
        end
        n_sat = i_beat.black ? '0 : rtoh_pkg::SAT_W'(i_beat.sat_lo);
    end

    assign o_ready = !r_valid || !i_stall;

    // Output register; takes a new beat when empty or when the current one leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_hue       <= n_hue;
            r_sat       <= n_sat;
            r_val       <= rtoh_pkg::VAL_W'(i_beat.sat_den);
            r_hue_valid <= !i_beat.black;
        end
    end

    assign o_valid      = r_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_value      = r_val;
    assign o_hue_valid  = r_hue_valid;

endmodule

`default_nettype wire

FILE: rtl/rgb_to_hsv_converter.sv
// RGB to HSV conversion, one pixel per beat.
// Pipeline: one front stage for max, min and numerators, one cell per quotient
// bit (DIV_BITS cells), one output register. Throughput: one pixel per cycle
// while the output is not stalled; each cell stage holds its own beat and fills
// past a stalled output. Reset clears only the valid flags of every stage.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [rtoh_pkg::IN_W-1:0]  i_red,
    input  wire logic [rtoh_pkg::IN_W-1:0]  i_green,
    input  wire logic [rtoh_pkg::IN_W-1:0]  i_blue,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [rtoh_pkg::HUE_W-1:0]      o_hue,
    output logic [rtoh_pkg::SAT_W-1:0]      o_saturation,
    output logic [rtoh_pkg::VAL_W-1:0]      o_value,
    output logic                            o_hue_valid
);

    logic            front_ready;
    logic            chain_valid [rtoh_pkg::DIV_BITS+1];
    rtoh_pkg::t_beat chain_beat  [rtoh_pkg::DIV_BITS+1];
    logic            chain_ready [rtoh_pkg::DIV_BITS+1];

    // Front stage: channel compare and numerator set-up
    rtoh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_ready (front_ready),
        .o_valid (chain_valid[0]),
        .o_beat  (chain_beat[0]),
        .i_ready (chain_ready[0])
    );

    assign o_stall = !front_ready;

    // Row of divider cells, one quotient bit each
    for (genvar k = 0; k < rtoh_pkg::DIV_BITS; k++) begin : g_cell
        rtoh_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .i_beat  (chain_beat[k]),
            .o_ready (chain_ready[k]),
            .o_valid (chain_valid[k+1]),
            .o_beat  (chain_beat[k+1]),
            .i_ready (chain_ready[k+1])
        );
    end

    // Hue fix-up and output register
    rtoh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (chain_valid[rtoh_pkg::DIV_BITS]),
        .i_beat       (chain_beat[rtoh_pkg::DIV_BITS]),
        .o_ready      (chain_ready[rtoh_pkg::DIV_BITS]),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_value      (o_value),
        .o_hue_valid  (o_hue_valid)
    );

endmodule

`default_nettype wire
